>>> sv/obrb_pkg.sv
// ----------------------------------------------------------------------------
// obrb_pkg
// shared constants, result codes and the controller-to-datapath command
// bundle for the overwriting byte ring buffer
// ----------------------------------------------------------------------------
package obrb_pkg;

    // default storage depth in bytes
    localparam int DEPTH_DEF = 64;

    // field widths fixed by the interface
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;

    // a burst never delivers more than this many bytes
    localparam logic [CNT_W-1:0] MAX_BURST = 7'd64;

    // request opcodes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERWRITE = 2'd2;

    // one command per cycle from the controller to the datapath
    typedef struct packed {
        logic              wr_en;   // store one byte at head
        logic              rd_en;   // fetch one byte at tail
        logic              emit;    // produce a result for this command
        logic              last;    // final result of the request
        logic [STAT_W-1:0] status;  // status code of the result
    } t_cmd;

endpackage

>>> sv/obrb_dpath.sv
// ----------------------------------------------------------------------------
// obrb_dpath
// byte storage, head/tail pointers, fill level and the registered result
// outputs; acts on one command from the controller each cycle
// ----------------------------------------------------------------------------
module obrb_dpath #(
    parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  obrb_pkg::t_cmd                   i_cmd,
    input  logic [obrb_pkg::BYTE_W-1:0]      i_wr_byte,
    output logic [$clog2(DEPTH+1)-1:0]       o_fill,
    output logic                             o_valid,
    output logic [obrb_pkg::BYTE_W-1:0]      o_rd_byte,
    output logic                             o_has_byte,
    output logic                             o_last,
    output logic [obrb_pkg::STAT_W-1:0]      o_status,
    output logic [obrb_pkg::CNT_W-1:0]       o_free_space
);
    import obrb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
    localparam logic [FW-1:0] DepthW  = FW'(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [PW-1:0] head_inc, tail_inc;
    logic [FW-1:0] free_full;

    logic              r_valid;
    logic              r_has;
    logic              r_last;
    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_free;

    // pointer wrap at the end of storage
    assign head_inc = (r_head == PtrLast) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == PtrLast) ? '0 : r_tail + 1'b1;

    // next pointer and fill values
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.wr_en) begin
            n_head = head_inc;
            if (r_fill == DepthW) begin
                n_tail = head_inc;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end else if (i_cmd.rd_en) begin
            n_tail = tail_inc;
            n_fill = r_fill - 1'b1;
        end
    end

    assign free_full = DepthW - n_fill;

    // control state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
            r_has   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_valid <= i_cmd.emit;
            r_has   <= i_cmd.rd_en;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_last   <= i_cmd.last;
        r_status <= i_cmd.status;
        r_free   <= CNT_W'(free_full);
    end

    // byte storage, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_head] <= i_wr_byte;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_tail];
        end
    end

    assign o_fill       = r_fill;
    assign o_valid      = r_valid;
    assign o_rd_byte    = r_has ? r_rdata : '0;
    assign o_has_byte   = r_has;
    assign o_last       = r_last;
    assign o_status     = r_status;
    assign o_free_space = r_free;

endmodule

>>> sv/obrb_ctrl.sv
// ----------------------------------------------------------------------------
// obrb_ctrl
// request sequencer: decodes a request, sizes a read burst and steps the
// datapath one byte per cycle until the burst is done
// ----------------------------------------------------------------------------
module obrb_ctrl #(
    parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [obrb_pkg::CNT_W-1:0]    i_read_count,
    input  logic [$clog2(DEPTH+1)-1:0]    i_fill,
    output obrb_pkg::t_cmd                o_cmd
);
    import obrb_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > CNT_W) ? FW : CNT_W;
    localparam logic [FW-1:0] DepthW = FW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_BURST
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_remain, n_remain;

    logic [CNT_W-1:0] req_sat;
    logic [CNT_W-1:0] burst_len;
    logic             accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // burst length: request capped at the burst limit and at the fill
    assign req_sat   = (i_read_count > MAX_BURST) ? MAX_BURST : i_read_count;
    assign burst_len = (CW'(i_fill) < CW'(req_sat)) ? CNT_W'(i_fill) : req_sat;

    // command decode and sequencing
    always_comb begin
        n_state  = r_state;
        n_remain = r_remain;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.emit = 1'b1;
                    if (i_cmd == CMD_WRITE) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.last   = 1'b1;
                        o_cmd.status = (i_fill == DepthW) ? ST_OVERWRITE : ST_OK;
                    end else if (i_fill == '0) begin
                        o_cmd.last   = 1'b1;
                        o_cmd.status = ST_EMPTY;
                    end else if (burst_len == '0) begin
                        o_cmd.last   = 1'b1;
                        o_cmd.status = ST_OK;
                    end else begin
                        // first byte goes out right away
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.status = ST_OK;
                        o_cmd.last   = (burst_len == CNT_W'(1));
                        if (burst_len != CNT_W'(1)) begin
                            n_remain = burst_len - 1'b1;
                            n_state  = S_BURST;
                        end
                    end
                end
            end
            S_BURST: begin
                o_cmd.emit   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.status = ST_OK;
                o_cmd.last   = (r_remain == CNT_W'(1));
                n_remain     = r_remain - 1'b1;
                if (r_remain == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and burst counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
        end
    end

endmodule

>>> sv/overwriting_byte_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_unit
// byte ring buffer of DEPTH entries; a full buffer overwrites its oldest byte
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A write, a read on
// an empty buffer and a zero-length read each give one result, shown with
// o_valid for one cycle in the cycle after the request; busy stays low, so a
// new request may follow in the very next cycle. A read of n bytes (n is the
// request capped at 64 and at the current fill) gives n results on
// consecutive cycles, oldest byte first, o_last on the final one; busy stays
// high while the remaining bytes are read, since the single read port of the
// byte store delivers one byte a cycle through its output register. Every
// result carries the free space after it. Results cannot be held off: the
// receiver must take o_valid whenever it is high.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_unit #(
    parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [obrb_pkg::BYTE_W-1:0]   i_wr_byte,
    input  logic [obrb_pkg::CNT_W-1:0]    i_read_count,
    output logic                          o_valid,
    output logic [obrb_pkg::BYTE_W-1:0]   o_rd_byte,
    output logic                          o_has_byte,
    output logic                          o_last,
    output logic [obrb_pkg::STAT_W-1:0]   o_status,
    output logic [obrb_pkg::CNT_W-1:0]    o_free_space
);
    import obrb_pkg::*;

    t_cmd                       cmd;
    logic [$clog2(DEPTH+1)-1:0] fill;

    // request sequencer
    obrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_read_count (i_read_count),
        .i_fill       (fill),
        .o_cmd        (cmd)
    );

    // storage and result registers
    obrb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_byte    (i_wr_byte),
        .o_fill       (fill),
        .o_valid      (o_valid),
        .o_rd_byte    (o_rd_byte),
        .o_has_byte   (o_has_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_free_space (o_free_space)
    );

endmodule

>>> sv/obrb_checker.sv
// ----------------------------------------------------------------------------
// obrb_checker
// port-level checks for the overwriting byte ring buffer, bound to the top
// ----------------------------------------------------------------------------
module obrb_checker #(
    parameter int DEPTH = obrb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_valid,
    input  logic                          o_has_byte,
    input  logic                          o_last,
    input  logic [obrb_pkg::STAT_W-1:0]   o_status,
    input  logic [obrb_pkg::CNT_W-1:0]    o_free_space
);
    import obrb_pkg::*;

    localparam logic [CNT_W-1:0] DepthFree = CNT_W'(DEPTH);

    // every request answers in the next cycle
    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_valid)
        else $error("request not answered in the next cycle");

    // a burst keeps delivering bytes until its last one
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && o_has_byte)
        else $error("burst broken before its last byte");

    // results without a byte always close their request
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_last)
        else $error("byteless result not marked last");

    // delivered bytes carry ok status
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_byte |-> o_status == ST_OK)
        else $error("delivered byte with non-ok status");

    // an empty read reports a fully free buffer
    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_free_space == DepthFree && !o_has_byte)
        else $error("empty read with wrong free space");

endmodule

bind overwriting_byte_ring_buffer_unit obrb_checker #(
    .DEPTH (DEPTH)
) u_obrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_has_byte   (o_has_byte),
    .o_last       (o_last),
    .o_status     (o_status),
    .o_free_space (o_free_space)
);
